/* design/ihbf_pkg.sv */
// shared types and constants for the identifier hash bucket fold block
// no dependencies
`default_nettype none

package ihbf_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int HASH_WIDTH      = 32;
   localparam int FOLD_WIDTH      = 31;
   localparam int BUCKET_WIDTH    = 16;
   localparam int FOLD_CNT_WIDTH  = 5;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = 1;
   localparam int QUEUE_CNT_WIDTH = 2;

   localparam int MIX_XOR_SHIFT   = 13;
   localparam int MIX_ADD_SHIFT   = 7;
   localparam int MIX_RIGHT_SHIFT = 3;
   localparam int MIX_ROTATE      = 2;

   localparam logic [BUCKET_WIDTH-1:0]   BUCKET_RESET = 16'd256;
   localparam logic [BUCKET_WIDTH-1:0]   BUCKET_MIN   = 16'd2;
   localparam logic [FOLD_CNT_WIDTH-1:0] FOLD_LAST_STEP =
      FOLD_CNT_WIDTH'(FOLD_WIDTH - 1);

   // head of the hash queue as seen by the fold unit
   typedef struct packed {
      logic                  valid;
      logic [FOLD_WIDTH-1:0] value;
   } fold_head_type;

   typedef enum logic [1:0] {
      FOLD_IDLE,
      FOLD_CHECK,
      FOLD_DIV,
      FOLD_DONE
   } fold_state_type;

   // one byte of the mix: xor, add, xor, xor, then rotate left
   function automatic logic [HASH_WIDTH-1:0] mix_byte(
      input logic [HASH_WIDTH-1:0] acc,
      input logic [BYTE_WIDTH-1:0] c
   );
      logic [HASH_WIDTH-1:0] cw;
      logic [HASH_WIDTH-1:0] v;
      cw = HASH_WIDTH'(c);
      v  = acc ^ (cw << MIX_XOR_SHIFT);
      v  = v + (cw << MIX_ADD_SHIFT);
      v  = v ^ cw;
      v  = v ^ (cw >> MIX_RIGHT_SHIFT);
      return {v[HASH_WIDTH-MIX_ROTATE-1:0], v[HASH_WIDTH-1 -: MIX_ROTATE]};
   endfunction

endpackage

`default_nettype wire

/* design/ihbf_mix_front.sv */
// front end: takes identifier bytes and mixes them into the accumulator
// depends on ihbf_pkg
`default_nettype none

module ihbf_mix_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [ihbf_pkg::BYTE_WIDTH-1:0] req_tdata,
   input  wire logic                           req_tlast,
   input  wire logic                           queue_full,
   output logic                                push,
   output logic [ihbf_pkg::FOLD_WIDTH-1:0]     push_value
);
   import ihbf_pkg::*;

   logic [HASH_WIDTH-1:0] mix_acc_ff;
   logic [HASH_WIDTH-1:0] mix_acc_in;
   logic [HASH_WIDTH-1:0] mixed;
   logic                  accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign mixed      = mix_byte(mix_acc_ff, req_tdata);
   assign push       = accept && req_tlast;
   assign push_value = mixed[FOLD_WIDTH-1:0];

   always_comb begin
      mix_acc_in = mix_acc_ff;
      if (accept) begin
         // last byte closes the identifier: start over from zero
         mix_acc_in = req_tlast ? '0 : mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_acc_ff <= '0;
      end else begin
         mix_acc_ff <= mix_acc_in;
      end
   end

endmodule

`default_nettype wire

/* design/ihbf_queue.sv */
// two-entry queue of masked hashes between the mix front and the fold unit
// depends on ihbf_pkg
`default_nettype none

module ihbf_queue (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [ihbf_pkg::FOLD_WIDTH-1:0] push_value,
   output logic                                full,
   input  wire logic                           pop,
   output ihbf_pkg::fold_head_type             head
);
   import ihbf_pkg::*;

   logic [FOLD_WIDTH-1:0]      entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_in;
   logic                       do_pop;

   assign full       = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.value = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_value;
      end
   end

endmodule

`default_nettype wire

/* design/ihbf_fold_back.sv */
// back end: folds a hash below the bucket count with a bit-serial divider
// depends on ihbf_pkg
`default_nettype none

module ihbf_fold_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [ihbf_pkg::BUCKET_WIDTH-1:0] bucket_count,
   input  wire ihbf_pkg::fold_head_type          head,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [ihbf_pkg::BUCKET_WIDTH-1:0]     rsp_tdata
);
   import ihbf_pkg::*;

   fold_state_type            state_ff;
   fold_state_type            state_in;
   logic [FOLD_WIDTH-1:0]     value_ff;
   logic [FOLD_WIDTH-1:0]     value_in;
   logic [FOLD_WIDTH-1:0]     quo_ff;
   logic [FOLD_WIDTH-1:0]     quo_in;
   logic [BUCKET_WIDTH-1:0]   rem_ff;
   logic [BUCKET_WIDTH-1:0]   rem_in;
   logic [FOLD_CNT_WIDTH-1:0] step_ff;
   logic [FOLD_CNT_WIDTH-1:0] step_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic [BUCKET_WIDTH-1:0]   out_data_ff;
   logic [BUCKET_WIDTH-1:0]   out_data_in;

   logic [BUCKET_WIDTH:0]     rem_shift;
   logic [BUCKET_WIDTH:0]     rem_diff;
   logic                      rem_ge;
   logic                      out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign rem_shift = {rem_ff, quo_ff[FOLD_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, bucket_count};
   assign rem_ge    = (rem_shift >= {1'b0, bucket_count});

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      pop          = 1'b0;

      case (state_ff)
         FOLD_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               // a count below two has no fold: the bucket is zero
               value_in = (bucket_count < BUCKET_MIN) ? '0 : head.value;
               state_in = (bucket_count < BUCKET_MIN) ? FOLD_DONE : FOLD_CHECK;
            end
         end
         FOLD_CHECK: begin
            if (value_ff < FOLD_WIDTH'(bucket_count)) begin
               state_in = FOLD_DONE;
            end else begin
               quo_in   = value_ff;
               rem_in   = '0;
               step_in  = '0;
               state_in = FOLD_DIV;
            end
         end
         FOLD_DIV: begin
            rem_in  = rem_ge ? rem_diff[BUCKET_WIDTH-1:0] : rem_shift[BUCKET_WIDTH-1:0];
            quo_in  = {quo_ff[FOLD_WIDTH-2:0], rem_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == FOLD_LAST_STEP) begin
               // quotient plus remainder, then test again
               value_in = quo_in + FOLD_WIDTH'(rem_in);
               state_in = FOLD_CHECK;
            end
         end
         FOLD_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = value_ff[BUCKET_WIDTH-1:0];
               state_in     = FOLD_IDLE;
            end
         end
         default: begin
            state_in = FOLD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FOLD_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire

/* design/id_hash_bucket_fold.sv */
// top level of the identifier hash bucket fold block
// depends on ihbf_pkg, ihbf_mix_front, ihbf_queue, ihbf_fold_back
`default_nettype none

// Identifier hash to bucket. Bytes of an identifier enter on the req_ stream
// last character first, one item per byte, with tlast on the identifier's
// first character. Each byte is mixed into a 32-bit accumulator in the cycle
// it is accepted, so bytes go in at one per clock. When the closing byte is
// taken, the hash is masked to 31 bits and put in a two-entry queue, and the
// accumulator restarts at zero. A fold unit behind the queue replaces the
// value by quotient plus remainder of division by bucket_count until it is
// below bucket_count, and sends the bucket out on the rsp_ stream, one item
// per identifier. The divider is bit-serial: each fold round is 31 divide
// steps and a range check, and each identifier also takes a load and a
// hand-off to the output register. The number of rounds depends on the
// hash and the count: one or two for large counts, up to about 30 for a
// count of two. The input stalls only when two hashes are waiting on the
// fold unit. bucket_count resets to 256; the user must write it through
// csr_wen/csr_wdata only while the block is idle, which the block itself
// does not enforce; a count below two gives bucket 0.

module id_hash_bucket_fold (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wen,
   input  wire logic [15:0] csr_wdata,    // bucket_count
   // byte input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] id_byte
   input  wire logic        req_tlast,    // last_byte
   // bucket output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata     // [15:0] bucket
);
   import ihbf_pkg::*;

   logic [BUCKET_WIDTH-1:0] bucket_count_ff;
   logic [BUCKET_WIDTH-1:0] bucket_count_in;

   // front to queue
   logic                    push;
   logic [FOLD_WIDTH-1:0]   push_value;
   logic                    queue_full;

   // queue to fold unit
   fold_head_type           head;
   logic                    pop;

   assign bucket_count_in = csr_wen ? csr_wdata : bucket_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_RESET;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   // mixes one byte per accepted item
   ihbf_mix_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_value (push_value)
   );

   // decouples the mixer from the slow fold
   ihbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (push_value),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   // folds each hash below the bucket count and holds the result
   ihbf_fold_back u_back (
      .clock        (clock),
      .reset        (reset),
      .bucket_count (bucket_count_ff),
      .head         (head),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

`default_nettype wire
